// ===== rtl/ssnf_pkg.sv =====
// Shared types, constants and helpers for the seven-segment number formatter.
// No dependencies.
package ssnf_pkg;

    localparam int unsigned NUM_SLOTS = 6;
    localparam logic [3:0] FIRST_SLOT_POS = 4'd3;
    localparam logic [3:0] LAST_POS = 4'd8;

    localparam logic OP_NUMBER = 1'b0;
    localparam logic OP_PAIRS = 1'b1;

    typedef logic [NUM_SLOTS-1:0][3:0] ssnf_slots_t;

    // Word between conversion stages: {bcd[19:0], binary[15:0]} plus pair digits.
    typedef struct packed {
        logic        op;
        logic [35:0] work;
        ssnf_slots_t pair_digits;
    } ssnf_stage_t;

    // Word handed to the frame serializer.
    typedef struct packed {
        logic [3:0]  start_pos;
        ssnf_slots_t slots;
    } ssnf_frame_t;

    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // One shift-add-3 step over the five BCD digits.
    function automatic logic [35:0] dabble_step(input logic [35:0] w);
        logic [35:0] a;
        a = w;
        for (int j = 0; j < 5; j++)
        begin
            if (a[16 + 4*j +: 4] >= 4'd5)
                a[16 + 4*j +: 4] = a[16 + 4*j +: 4] + 4'd3;
        end
        return {a[34:0], 1'b0};
    endfunction

    function automatic logic [35:0] dabble4(input logic [35:0] w);
        logic [35:0] a;
        a = w;
        for (int k = 0; k < 4; k++)
        begin
            a = dabble_step(a);
        end
        return a;
    endfunction

    // Saturate to 99 and split into {tens, units}; tens via x*205 >> 11.
    function automatic logic [7:0] split_pair(input logic [7:0] v);
        logic [6:0]  sat;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        sat = (v > 8'd99) ? 7'd99 : v[6:0];
        prod = 15'(sat) * 15'd205;
        tens = prod[14:11];
        units = sat - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

endpackage

// ===== rtl/seven_segment_number_formatter_unit.sv =====
// Top level of the seven-segment number formatter: conversion pipeline and frame serializer.
// Depends on ssnf_pkg.
//
// A request (start high while busy is low) is turned into 1 to 6 digit frames, one per
// cycle, each marked by strobe for a single cycle; the receiver cannot hold frames off.
// A request passes through four conversion stages, then the serializer, before its first
// frame appears. Requests may be issued in consecutive cycles; the pipeline buffers up to
// four of them, and the serializer then sets the sustained rate: one request per run of
// frames, whose frame count is 1 to 5 in number mode and 5 or 6 in pair mode. busy
// rises only when all conversion stages are full behind a request still emitting frames.
module seven_segment_number_formatter_unit
    import ssnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] number_value,
    input  logic [7:0]  first_pair,
    input  logic [7:0]  second_pair,
    input  logic [7:0]  third_pair,
    output logic        strobe,
    output logic [7:0]  segment_code,
    output logic [7:0]  digit_select,
    output logic [3:0]  position,
    output logic        last
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, ser_valid_reg;
    ssnf_stage_t s1_reg, s2_reg, s3_reg;
    ssnf_stage_t s1_next, s2_next, s3_next;
    ssnf_frame_t s4_reg, s4_next;
    logic [3:0]  pos_reg;
    ssnf_slots_t slots_reg;

    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic ser_last, ser_load, accept;

    assign ser_last = (pos_reg == LAST_POS);
    assign ser_load = !ser_valid_reg || ser_last;
    assign s4_ready = !s4_valid_reg || ser_load;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign busy = !s1_ready;
    assign accept = start && !busy;

    // Stage 1: capture, pair split, first four conversion steps
    always_comb
    begin
        s1_next.op = op;
        s1_next.work = dabble4({20'd0, number_value});
        {s1_next.pair_digits[0], s1_next.pair_digits[1]} = split_pair(first_pair);
        {s1_next.pair_digits[2], s1_next.pair_digits[3]} = split_pair(second_pair);
        {s1_next.pair_digits[4], s1_next.pair_digits[5]} = split_pair(third_pair);
    end

    always_comb
    begin
        s2_next = s1_reg;
        s2_next.work = dabble4(s1_reg.work);
        s3_next = s2_reg;
        s3_next.work = dabble4(s2_reg.work);
    end

    // Stage 4: last steps, digit slots for positions 3..8 and first shown position
    always_comb
    begin
        logic [35:0] w;
        w = dabble4(s3_reg.work);
        if (s3_reg.op == OP_PAIRS)
        begin
            s4_next.slots = s3_reg.pair_digits;
            s4_next.start_pos = (s3_reg.pair_digits[0] != 4'd0) ? 4'd3 : 4'd4;
        end
        else
        begin
            s4_next.slots[0] = 4'd0;
            for (int i = 0; i < 5; i++)
            begin
                s4_next.slots[i+1] = w[32 - 4*i +: 4];
            end
            if (w[35:32] != 4'd0)
                s4_next.start_pos = 4'd4;
            else if (w[31:28] != 4'd0)
                s4_next.start_pos = 4'd5;
            else if (w[27:24] != 4'd0)
                s4_next.start_pos = 4'd6;
            else if (w[23:20] != 4'd0)
                s4_next.start_pos = 4'd7;
            else
                s4_next.start_pos = LAST_POS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            ser_valid_reg <= 1'b0;
            pos_reg <= LAST_POS;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= accept;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (ser_load)
            begin
                ser_valid_reg <= s4_valid_reg;
                pos_reg <= s4_reg.start_pos;
            end
            else
                pos_reg <= pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
            s1_reg <= s1_next;
        if (s2_ready)
            s2_reg <= s2_next;
        if (s3_ready)
            s3_reg <= s3_next;
        if (s4_ready)
            s4_reg <= s4_next;
        if (ser_load)
            slots_reg <= s4_reg.slots;
    end

    logic [2:0] slot_off;
    logic [2:0] sel_bit;

    // positions 3..8 map to slots 0..5
    assign slot_off = pos_reg[2:0] - FIRST_SLOT_POS[2:0];
    assign sel_bit = pos_reg[2:0] - 3'd1;

    assign strobe = ser_valid_reg;
    assign segment_code = seg_of_digit(slots_reg[slot_off]);
    assign digit_select = ~(8'd1 << sel_bit);
    assign position = pos_reg;
    assign last = ser_last;

`ifndef NO_ASSERTIONS
    a_frames_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("frame run broken before last frame");

    a_position_steps: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> position == $past(position) + 4'd1)
        else $error("position did not advance by one");

    a_last_at_right: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (position == LAST_POS)) && position >= FIRST_SLOT_POS)
        else $error("last mark or position out of place");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && strobe)
        else $error("busy raised while pipeline has room");
`endif

endmodule
